### rtl/core/mbet_pkg.sv
`default_nettype none

package mbet_pkg;

    localparam int INDEX_BITS    = 12;
    localparam int FRACTION_BITS = 28;
    localparam int COORD_W       = 32;
    localparam int COUNT_W       = 16;
    localparam int GREY_W        = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    localparam int CPROD_W  = INDEX_BITS + 1 + COORD_W;
    localparam int PROD_W   = 2 * COORD_W;
    localparam int SQ_W     = PROD_W - FRACTION_BITS;
    localparam int XY_W     = PROD_W - FRACTION_BITS + 1;
    localparam int SAT_W    = ((CPROD_W > XY_W) ? CPROD_W : XY_W) + 2;
    localparam int SQSUM_W  = ((SQ_W + 1) > (FRACTION_BITS + 3)) ? (SQ_W + 1)
                                                                  : (FRACTION_BITS + 3);
    localparam int DIV_W    = COUNT_W + GREY_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [SQSUM_W-1:0] ESCAPE_BOUND = SQSUM_W'(4) << FRACTION_BITS;

    typedef logic [INDEX_BITS-1:0]    t_index;
    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [COUNT_W-1:0]       t_count;
    typedef logic [GREY_W-1:0]        t_grey;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_REAL     = 3'd0,
        CFG_ORIGIN_IMAG     = 3'd1,
        CFG_STEP_REAL       = 3'd2,
        CFG_STEP_IMAG       = 3'd3,
        CFG_ITERATION_LIMIT = 3'd4
    } t_cfg_index;

    localparam t_coord ORIGIN_REAL_RST     = 32'hE000_0000;
    localparam t_coord ORIGIN_IMAG_RST     = 32'hE800_0000;
    localparam t_coord STEP_REAL_RST       = 32'h000C_0000;
    localparam t_coord STEP_IMAG_RST       = 32'h000C_0000;
    localparam t_count ITERATION_LIMIT_RST = 16'd1024;

    typedef struct packed {
        t_index column;
        t_index row;
    } t_in_item;

    typedef struct packed {
        t_grey  grey_level;
        t_count iteration_count;
    } t_out_item;

    typedef struct packed {
        logic load_in;
        logic coord_mul;
        logic coord_add;
        logic iter_mul;
        logic iter_step;
        logic div_init;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic cont;
    } t_dp_status;

    function automatic t_coord sat_coord(input logic signed [SAT_W-1:0] v);
        logic [SAT_W-COORD_W:0] top_bits;
        top_bits = v[SAT_W-1:COORD_W-1];
        if ((&top_bits) || !(|top_bits)) begin
            sat_coord = v[COORD_W-1:0];
        end else if (v[SAT_W-1]) begin
            sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

### rtl/core/mbet_ctrl.sv
`default_nettype none

module mbet_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    input  wire mbet_pkg::t_dp_status i_status,
    output mbet_pkg::t_dp_cmd        o_cmd
);
    import mbet_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CMUL  = 7'b0000010,
        ST_CADD  = 7'b0000100,
        ST_IMUL  = 7'b0001000,
        ST_ISTEP = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [DIV_CNT_W-1:0] n_div_cnt;
    logic                 r_out_valid;
    logic                 n_out_valid;
    t_dp_cmd              cmd;

    always_comb begin
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_in = 1'b1;
                    n_state     = ST_CMUL;
                end
            end
            ST_CMUL: begin
                cmd.coord_mul = 1'b1;
                n_state       = ST_CADD;
            end
            ST_CADD: begin
                cmd.coord_add = 1'b1;
                n_state       = ST_IMUL;
            end
            ST_IMUL: begin
                cmd.iter_mul = 1'b1;
                n_state      = ST_ISTEP;
            end
            ST_ISTEP: begin
                if (i_status.cont) begin
                    cmd.iter_step = 1'b1;
                    n_state       = ST_IMUL;
                end else begin
                    cmd.div_init = 1'b1;
                    n_div_cnt    = DIV_CNT_W'(DIV_W - 1);
                    n_state      = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (r_div_cnt == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_div_cnt = r_div_cnt - DIV_CNT_W'(1);
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

`default_nettype wire

### rtl/core/mbet_datapath.sv
`default_nettype none

module mbet_datapath (
    input  wire logic                 i_clk,
    input  wire mbet_pkg::t_dp_cmd    i_cmd,
    output mbet_pkg::t_dp_status      o_status,
    input  wire mbet_pkg::t_in_item   i_in_data,
    input  wire mbet_pkg::t_coord     i_origin_real,
    input  wire mbet_pkg::t_coord     i_origin_imag,
    input  wire mbet_pkg::t_coord     i_step_real,
    input  wire mbet_pkg::t_coord     i_step_imag,
    input  wire mbet_pkg::t_count     i_limit,
    output mbet_pkg::t_out_item       o_out_data
);
    import mbet_pkg::*;

    t_index                     r_col;
    t_index                     r_row;
    logic signed [CPROD_W-1:0]  r_prod_r;
    logic signed [CPROD_W-1:0]  r_prod_i;
    t_coord                     r_cr;
    t_coord                     r_ci;
    t_coord                     r_x;
    t_coord                     r_y;
    logic signed [PROD_W-1:0]   r_pxx;
    logic signed [PROD_W-1:0]   r_pyy;
    logic signed [PROD_W-1:0]   r_pxy;
    t_count                     r_n;
    logic [DIV_W-1:0]           r_dvd;
    t_count                     r_rem;
    t_out_item                  r_out;

    logic signed [SAT_W-1:0]    cr_sum;
    logic signed [SAT_W-1:0]    ci_sum;
    logic [SQ_W-1:0]            x2;
    logic [SQ_W-1:0]            y2;
    logic [SQSUM_W-1:0]         sq_sum;
    logic [XY_W-1:0]            xy;
    logic signed [SAT_W-1:0]    nx_sum;
    logic signed [SAT_W-1:0]    ny_sum;
    logic [COUNT_W:0]           div_trial;
    logic [COUNT_W:0]           div_diff;
    logic                       div_ge;

    assign cr_sum = {{(SAT_W-CPROD_W){r_prod_r[CPROD_W-1]}}, r_prod_r}
                  + {{(SAT_W-COORD_W){i_origin_real[COORD_W-1]}}, i_origin_real};
    assign ci_sum = {{(SAT_W-CPROD_W){r_prod_i[CPROD_W-1]}}, r_prod_i}
                  + {{(SAT_W-COORD_W){i_origin_imag[COORD_W-1]}}, i_origin_imag};

    assign x2     = r_pxx[PROD_W-1:FRACTION_BITS];
    assign y2     = r_pyy[PROD_W-1:FRACTION_BITS];
    assign sq_sum = SQSUM_W'(x2) + SQSUM_W'(y2);
    assign xy     = r_pxy[PROD_W-1:FRACTION_BITS-1];

    assign nx_sum = {{(SAT_W-SQ_W){1'b0}}, x2} - {{(SAT_W-SQ_W){1'b0}}, y2}
                  + {{(SAT_W-COORD_W){r_cr[COORD_W-1]}}, r_cr};
    assign ny_sum = {{(SAT_W-XY_W){xy[XY_W-1]}}, xy}
                  + {{(SAT_W-COORD_W){r_ci[COORD_W-1]}}, r_ci};

    assign o_status.cont = (sq_sum < ESCAPE_BOUND) && (r_n < i_limit);

    assign div_trial = {r_rem, r_dvd[DIV_W-1]};
    assign div_diff  = div_trial - {1'b0, i_limit};
    assign div_ge    = (div_trial >= {1'b0, i_limit});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_col <= i_in_data.column;
            r_row <= i_in_data.row;
        end
        if (i_cmd.coord_mul) begin
            r_prod_r <= $signed({1'b0, r_col}) * i_step_real;
            r_prod_i <= $signed({1'b0, r_row}) * i_step_imag;
        end
        if (i_cmd.coord_add) begin
            r_cr <= sat_coord(cr_sum);
            r_ci <= sat_coord(ci_sum);
            r_x  <= sat_coord(cr_sum);
            r_y  <= sat_coord(ci_sum);
            r_n  <= '0;
        end
        if (i_cmd.iter_mul) begin
            r_pxx <= r_x * r_x;
            r_pyy <= r_y * r_y;
            r_pxy <= r_x * r_y;
        end
        if (i_cmd.iter_step) begin
            r_x <= sat_coord(nx_sum);
            r_y <= sat_coord(ny_sum);
            r_n <= r_n + COUNT_W'(1);
        end
        if (i_cmd.div_init) begin
            // The scale factor 255 is formed as n * 256 - n.
            r_dvd <= {r_n, GREY_W'(0)} - DIV_W'(r_n);
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_ge ? div_diff[COUNT_W-1:0] : div_trial[COUNT_W-1:0];
            r_dvd <= {r_dvd[DIV_W-2:0], div_ge};
        end
        if (i_cmd.out_load) begin
            r_out.iteration_count <= r_n;
            r_out.grey_level      <= (i_limit == '0) ? '0 : r_dvd[GREY_W-1:0];
        end
    end

    assign o_out_data = r_out;

endmodule

`default_nettype wire

### rtl/core/mandelbrot_escape_time_pixel_unit.sv
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_in_data  (column, row)
// out       output     o_out_valid / i_out_ready  o_out_data (grey_level, iteration_count)
// cfg       input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// Each pixel maps its point onto the plane, iterates the orbit through three
// 32x32 multipliers, and forms its grey level in a bit-serial divider.
// Reset is synchronous and active low; it restores the default view and limit.
// A finished result waits in the output register while the next pixel is taken;
// a pixel finishing while that register is still full holds until it drains.
`default_nettype none

module mandelbrot_escape_time_pixel_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire mbet_pkg::t_in_item         i_in_data,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output mbet_pkg::t_out_item             o_out_data,
    input  wire logic                       i_cfg_we,
    input  wire logic [mbet_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [mbet_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mbet_pkg::*;

    t_coord     r_origin_real;
    t_coord     r_origin_imag;
    t_coord     r_step_real;
    t_coord     r_step_imag;
    t_count     r_limit;
    t_dp_cmd    cmd;
    t_dp_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_real <= ORIGIN_REAL_RST;
            r_origin_imag <= ORIGIN_IMAG_RST;
            r_step_real   <= STEP_REAL_RST;
            r_step_imag   <= STEP_IMAG_RST;
            r_limit       <= ITERATION_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ORIGIN_REAL:     r_origin_real <= i_cfg_data[COORD_W-1:0];
                CFG_ORIGIN_IMAG:     r_origin_imag <= i_cfg_data[COORD_W-1:0];
                CFG_STEP_REAL:       r_step_real   <= i_cfg_data[COORD_W-1:0];
                CFG_STEP_IMAG:       r_step_imag   <= i_cfg_data[COORD_W-1:0];
                CFG_ITERATION_LIMIT: r_limit       <= i_cfg_data[COUNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mbet_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    mbet_datapath u_datapath (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_in_data     (i_in_data),
        .i_origin_real (r_origin_real),
        .i_origin_imag (r_origin_imag),
        .i_step_real   (r_step_real),
        .i_step_imag   (r_step_imag),
        .i_limit       (r_limit),
        .o_out_data    (o_out_data)
    );

endmodule

`default_nettype wire

### rtl/core/mbet_checker.sv
`default_nettype none

module mbet_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire mbet_pkg::t_out_item o_out_data
);
    import mbet_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("Result item dropped before it was taken.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_out_data))
        else $error("Result item changed while stalled.");

    a_zero_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.iteration_count == '0)) |->
        (o_out_data.grey_level == '0))
        else $error("Nonzero grey level for a zero iteration count.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("Input taken again before the current item was worked.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Result valid after reset.");

endmodule

bind mandelbrot_escape_time_pixel_unit mbet_checker u_mbet_checker (.*);

`default_nettype wire
